[src/tsq_pkg.sv]
// shared constants, beat types and fifo command structs for the trimming switch queue
// no dependencies
package tsq_pkg;

   localparam int TAG_WIDTH     = 16;
   localparam int DATA_DEPTH    = 64;
   localparam int HEADER_DEPTH  = 64;
   localparam int CONTROL_DEPTH = 32;
   localparam int CAP_WIDTH     = 7;
   localparam int SHARE_PERIOD  = 10;
   localparam int SHARE_W       = $clog2(SHARE_PERIOD);

   localparam int DPTR_W = $clog2(DATA_DEPTH);
   localparam int HPTR_W = $clog2(HEADER_DEPTH);
   localparam int CPTR_W = $clog2(CONTROL_DEPTH);
   localparam int DCNT_W = $clog2(DATA_DEPTH + 1);
   localparam int HCNT_W = $clog2(HEADER_DEPTH + 1);
   localparam int CCNT_W = $clog2(CONTROL_DEPTH + 1);
   localparam int CMP_W  = (DCNT_W > CAP_WIDTH) ? DCNT_W : CAP_WIDTH;
   localparam int HDR_W  = TAG_WIDTH + 1;

   localparam logic [CAP_WIDTH-1:0] CAP_RESET = CAP_WIDTH'(32);

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   localparam logic [1:0] SRC_CONTROL = 2'd0;
   localparam logic [1:0] SRC_HEADER  = 2'd1;
   localparam logic [1:0] SRC_DATA    = 2'd2;

   localparam logic [2:0] ST_CONTROL = 3'd0;
   localparam logic [2:0] ST_HEADER  = 3'd1;
   localparam logic [2:0] ST_TRIMMED = 3'd2;
   localparam logic [2:0] ST_DATA    = 3'd3;
   localparam logic [2:0] ST_DROPPED = 3'd4;

   typedef struct packed {
      logic                 func;
      logic [TAG_WIDTH-1:0] packet_tag;
      logic                 ack_flag;
      logic                 syn_flag;
      logic                 nack_flag;
      logic                 header_only;
      logic                 pull_flag;
   } req_type;

   typedef struct packed {
      logic                 out_valid;
      logic [TAG_WIDTH-1:0] out_tag;
      logic                 out_trimmed;
      logic [1:0]           out_source;
      logic [2:0]           push_status;
   } rsp_type;

   // what the decision stage hands to the result stage
   typedef struct packed {
      logic       valid;
      logic       hit;
      logic [1:0] source;
      logic [2:0] status;
   } meta_type;

   typedef struct packed {
      logic                 wr_en;
      logic [DPTR_W-1:0]    wr_addr;
      logic [TAG_WIDTH-1:0] wr_data;
      logic                 rd_en;
      logic [DPTR_W-1:0]    rd_addr;
   } dcmd_type;

   typedef struct packed {
      logic              wr_en;
      logic [HPTR_W-1:0] wr_addr;
      logic [HDR_W-1:0]  wr_data;
      logic              rd_en;
      logic [HPTR_W-1:0] rd_addr;
   } hcmd_type;

   typedef struct packed {
      logic                 wr_en;
      logic [CPTR_W-1:0]    wr_addr;
      logic [TAG_WIDTH-1:0] wr_data;
      logic                 rd_en;
      logic [CPTR_W-1:0]    rd_addr;
   } ccmd_type;

endpackage

[src/tsq_ram.sv]
// generic single write, single read ram with registered read data
// no dependencies
module tsq_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/tsq_ctrl.sv]
// push/pop decision stage: counts, pointers, share counter, capacity register
// depends on tsq_pkg
module tsq_ctrl import tsq_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 item_valid,
   input  req_type              item,
   input  logic                 csr_wr_en,
   input  logic [CAP_WIDTH-1:0] csr_wr_data,
   output dcmd_type             dcmd,
   output hcmd_type             hcmd,
   output ccmd_type             ccmd,
   output meta_type             meta
);

   localparam logic [DPTR_W-1:0] DPTR_LAST  = DPTR_W'(DATA_DEPTH - 1);
   localparam logic [HPTR_W-1:0] HPTR_LAST  = HPTR_W'(HEADER_DEPTH - 1);
   localparam logic [CPTR_W-1:0] CPTR_LAST  = CPTR_W'(CONTROL_DEPTH - 1);
   localparam logic [SHARE_W-1:0] SHR_LAST  = SHARE_W'(SHARE_PERIOD - 1);

   logic [CAP_WIDTH-1:0] cap_ff, cap_in;
   logic [DCNT_W-1:0]    dcnt_ff, dcnt_in;
   logic [HCNT_W-1:0]    hcnt_ff, hcnt_in;
   logic [CCNT_W-1:0]    ccnt_ff, ccnt_in;
   logic [DPTR_W-1:0]    drd_ff, drd_in, dwr_ff, dwr_in;
   logic [HPTR_W-1:0]    hrd_ff, hrd_in, hwr_ff, hwr_in;
   logic [CPTR_W-1:0]    crd_ff, crd_in, cwr_ff, cwr_in;
   logic [SHARE_W-1:0]   shr_ff, shr_in;
   meta_type             meta_ff, meta_in;

   logic is_ctrl, is_hdr, d_full, h_full, c_full, trim;
   logic d_push, h_push, c_push, d_pop, h_pop, c_pop;

   always_comb begin
      is_ctrl = item.ack_flag | item.syn_flag | item.nack_flag;
      is_hdr  = item.header_only | item.pull_flag;
      c_full  = ccnt_ff >= CCNT_W'(CONTROL_DEPTH);
      h_full  = hcnt_ff >= HCNT_W'(HEADER_DEPTH);
      d_full  = dcnt_ff >= DCNT_W'(DATA_DEPTH);
      trim    = (CMP_W'(dcnt_ff) >= CMP_W'(cap_ff)) | d_full;

      d_push = 1'b0;
      h_push = 1'b0;
      c_push = 1'b0;
      d_pop  = 1'b0;
      h_pop  = 1'b0;
      c_pop  = 1'b0;
      shr_in = shr_ff;

      meta_in.valid  = item_valid;
      meta_in.hit    = 1'b0;
      meta_in.source = SRC_CONTROL;
      meta_in.status = ST_CONTROL;

      if (item_valid && item.func == FUNC_PUSH) begin
         if (is_ctrl) begin
            c_push         = ~c_full;
            meta_in.status = c_full ? ST_DROPPED : ST_CONTROL;
         end else if (is_hdr) begin
            h_push         = ~h_full;
            meta_in.status = h_full ? ST_DROPPED : ST_HEADER;
         end else if (trim) begin
            h_push         = ~h_full;
            meta_in.status = h_full ? ST_DROPPED : ST_TRIMMED;
         end else begin
            d_push         = 1'b1;
            meta_in.status = ST_DATA;
         end
      end else if (item_valid) begin
         if (ccnt_ff != '0) begin
            c_pop = 1'b1;
         end else if (hcnt_ff == '0 && dcnt_ff != '0) begin
            d_pop = 1'b1;
         end else if (hcnt_ff != '0 && dcnt_ff == '0) begin
            h_pop = 1'b1;
         end else if (hcnt_ff != '0 && dcnt_ff != '0) begin
            d_pop  = (shr_ff == '0);
            h_pop  = (shr_ff != '0);
            shr_in = (shr_ff == SHR_LAST) ? '0 : shr_ff + SHARE_W'(1);
         end
         meta_in.hit    = c_pop | d_pop | h_pop;
         meta_in.source = c_pop ? SRC_CONTROL : (h_pop ? SRC_HEADER :
                          (d_pop ? SRC_DATA : SRC_CONTROL));
      end

      cap_in  = csr_wr_en ? csr_wr_data : cap_ff;
      ccnt_in = ccnt_ff + CCNT_W'(c_push) - CCNT_W'(c_pop);
      hcnt_in = hcnt_ff + HCNT_W'(h_push) - HCNT_W'(h_pop);
      dcnt_in = dcnt_ff + DCNT_W'(d_push) - DCNT_W'(d_pop);
      cwr_in  = c_push ? ((cwr_ff == CPTR_LAST) ? '0 : cwr_ff + CPTR_W'(1)) : cwr_ff;
      crd_in  = c_pop  ? ((crd_ff == CPTR_LAST) ? '0 : crd_ff + CPTR_W'(1)) : crd_ff;
      hwr_in  = h_push ? ((hwr_ff == HPTR_LAST) ? '0 : hwr_ff + HPTR_W'(1)) : hwr_ff;
      hrd_in  = h_pop  ? ((hrd_ff == HPTR_LAST) ? '0 : hrd_ff + HPTR_W'(1)) : hrd_ff;
      dwr_in  = d_push ? ((dwr_ff == DPTR_LAST) ? '0 : dwr_ff + DPTR_W'(1)) : dwr_ff;
      drd_in  = d_pop  ? ((drd_ff == DPTR_LAST) ? '0 : drd_ff + DPTR_W'(1)) : drd_ff;

      ccmd.wr_en   = c_push;
      ccmd.wr_addr = cwr_ff;
      ccmd.wr_data = item.packet_tag;
      ccmd.rd_en   = c_pop;
      ccmd.rd_addr = crd_ff;
      hcmd.wr_en   = h_push;
      hcmd.wr_addr = hwr_ff;
      hcmd.wr_data = {~is_ctrl & ~is_hdr, item.packet_tag};
      hcmd.rd_en   = h_pop;
      hcmd.rd_addr = hrd_ff;
      dcmd.wr_en   = d_push;
      dcmd.wr_addr = dwr_ff;
      dcmd.wr_data = item.packet_tag;
      dcmd.rd_en   = d_pop;
      dcmd.rd_addr = drd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= CAP_RESET;
         dcnt_ff <= '0;
         hcnt_ff <= '0;
         ccnt_ff <= '0;
         drd_ff  <= '0;
         dwr_ff  <= '0;
         hrd_ff  <= '0;
         hwr_ff  <= '0;
         crd_ff  <= '0;
         cwr_ff  <= '0;
         shr_ff  <= '0;
         meta_ff <= '0;
      end else begin
         cap_ff  <= cap_in;
         dcnt_ff <= dcnt_in;
         hcnt_ff <= hcnt_in;
         ccnt_ff <= ccnt_in;
         drd_ff  <= drd_in;
         dwr_ff  <= dwr_in;
         hrd_ff  <= hrd_in;
         hwr_ff  <= hwr_in;
         crd_ff  <= crd_in;
         cwr_ff  <= cwr_in;
         shr_ff  <= shr_in;
         meta_ff <= meta_in;
      end
   end

   assign meta = meta_ff;

endmodule

[src/tsq_out.sv]
// result stage: picks the served fifo's read data and registers the result beat
// depends on tsq_pkg
module tsq_out import tsq_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  meta_type             meta,
   input  logic [TAG_WIDTH-1:0] d_rd_data,
   input  logic [HDR_W-1:0]     h_rd_data,
   input  logic [TAG_WIDTH-1:0] c_rd_data,
   output logic                 rsp_strobe,
   output rsp_type              rsp_item
);

   logic    strobe_ff, strobe_in;
   rsp_type rsp_ff, rsp_in;

   always_comb begin
      strobe_in          = meta.valid;
      rsp_in.out_valid   = meta.hit;
      rsp_in.out_source  = meta.source;
      rsp_in.push_status = meta.status;
      rsp_in.out_tag     = '0;
      rsp_in.out_trimmed = 1'b0;
      if (meta.hit) begin
         case (meta.source)
            SRC_CONTROL: rsp_in.out_tag = c_rd_data;
            SRC_HEADER: begin
               rsp_in.out_tag     = h_rd_data[TAG_WIDTH-1:0];
               rsp_in.out_trimmed = h_rd_data[TAG_WIDTH];
            end
            SRC_DATA: rsp_in.out_tag = d_rd_data;
            default: rsp_in.out_tag = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

[src/trimming_switch_queue_core.sv]
// top level of the trimming switch queue: input register, decision stage, fifo rams, result stage
// depends on tsq_pkg, tsq_ctrl, tsq_ram, tsq_out
//
//   channel   handshake           payload         direction
//   request   start / busy        req_item        in
//   result    rsp_strobe          rsp_item        out
//   config    csr_wr_en           csr_wr_data     in
//
// one beat accepted every cycle while busy is low; its result beat passes through
// the input register, the registered ram read and the result register
// busy is high only during reset; fifos need no clearing pass
// synchronous reset clears counts, pointers, share counter and valids, and loads the capacity with CAP_RESET
// result beats cannot be held off by the receiver
module trimming_switch_queue_core import tsq_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_item,
   output logic                 rsp_strobe,
   output rsp_type              rsp_item,
   input  logic                 csr_wr_en,
   input  logic [CAP_WIDTH-1:0] csr_wr_data
);

   logic     req_valid_ff, req_valid_in;
   req_type  req_ff;
   dcmd_type dcmd;
   hcmd_type hcmd;
   ccmd_type ccmd;
   meta_type meta;
   logic [TAG_WIDTH-1:0] d_rd_data, c_rd_data;
   logic [HDR_W-1:0]     h_rd_data;

   assign busy         = reset;
   assign req_valid_in = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
      req_ff <= req_item;
   end

   tsq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (req_valid_ff),
      .item        (req_ff),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .dcmd        (dcmd),
      .hcmd        (hcmd),
      .ccmd        (ccmd),
      .meta        (meta)
   );

   tsq_ram #(.WIDTH(TAG_WIDTH), .DEPTH(DATA_DEPTH)) u_data_ram (
      .clock   (clock),
      .wr_en   (dcmd.wr_en),
      .wr_addr (dcmd.wr_addr),
      .wr_data (dcmd.wr_data),
      .rd_en   (dcmd.rd_en),
      .rd_addr (dcmd.rd_addr),
      .rd_data (d_rd_data)
   );

   tsq_ram #(.WIDTH(HDR_W), .DEPTH(HEADER_DEPTH)) u_header_ram (
      .clock   (clock),
      .wr_en   (hcmd.wr_en),
      .wr_addr (hcmd.wr_addr),
      .wr_data (hcmd.wr_data),
      .rd_en   (hcmd.rd_en),
      .rd_addr (hcmd.rd_addr),
      .rd_data (h_rd_data)
   );

   tsq_ram #(.WIDTH(TAG_WIDTH), .DEPTH(CONTROL_DEPTH)) u_control_ram (
      .clock   (clock),
      .wr_en   (ccmd.wr_en),
      .wr_addr (ccmd.wr_addr),
      .wr_data (ccmd.wr_data),
      .rd_en   (ccmd.rd_en),
      .rd_addr (ccmd.rd_addr),
      .rd_data (c_rd_data)
   );

   tsq_out u_out (
      .clock      (clock),
      .reset      (reset),
      .meta       (meta),
      .d_rd_data  (d_rd_data),
      .h_rd_data  (h_rd_data),
      .c_rd_data  (c_rd_data),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_strobe)
      else $error("accepted beat gave no result three cycles on");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, 3))
      else $error("result beat without an accepted request");

   a_pop_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.out_valid) |->
         (rsp_item.push_status == ST_CONTROL &&
          (rsp_item.out_source == SRC_HEADER || !rsp_item.out_trimmed)))
      else $error("pop result carries push status or stray trimmed mark");

endmodule

[dv/trimming_switch_queue_core_tb.sv]
// self-checking testbench for trimming_switch_queue_core: a directed table, then random phases
// over several trim capacities and sender idle rates, every result beat checked against the table or a predictor
// depends on tsq_pkg and trimming_switch_queue_core
`timescale 1ns / 1ps

module trimming_switch_queue_core_tb;
   import tsq_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_COUNT  = 6;
   localparam int PHASE_BEATS  = 85;
   localparam int SETTLE_TICKS = 4;

   typedef struct packed {
      logic                 set_cap;
      logic [CAP_WIDTH-1:0] cap;
      req_type              item;
      logic                 typed;
      rsp_type              want;
   } plan_row_type;

   localparam req_type POP_BEAT = '{func: FUNC_POP, default: '0};

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_type              req_item = '0;
   logic                 rsp_strobe;
   rsp_type              rsp_item;
   logic                 csr_wr_en = 1'b0;
   logic [CAP_WIDTH-1:0] csr_wr_data = '0;

   // queue state as the predictor sees it
   logic [CAP_WIDTH-1:0] capacity = CAP_RESET;
   logic [TAG_WIDTH-1:0] data_mem [DATA_DEPTH];
   logic [HDR_W-1:0]     hdr_mem  [HEADER_DEPTH];
   logic [TAG_WIDTH-1:0] ctl_mem  [CONTROL_DEPTH];
   int                   data_cnt = 0;
   int                   hdr_cnt  = 0;
   int                   ctl_cnt  = 0;
   logic [DPTR_W-1:0]    data_rd = '0, data_wr = '0;
   logic [HPTR_W-1:0]    hdr_rd  = '0, hdr_wr  = '0;
   logic [CPTR_W-1:0]    ctl_rd  = '0, ctl_wr  = '0;
   int                   share_turn = 0;

   rsp_type      awaited_outcomes [$];
   plan_row_type plan [$];

   int errors      = 0;
   int cycles      = 0;
   int beats_sent  = 0;
   int served_pops = 0;
   int trimmed_n   = 0;
   int dropped_n   = 0;
   int empty_pops  = 0;
   int cap_writes  = 0;

   int phase_cap  [PHASE_COUNT] = '{0, 64, 63, 5, 1, 17};
   int phase_idle [PHASE_COUNT] = '{0, 74, 27, 0, 74, 27};
   int phase_push [PHASE_COUNT] = '{95, 90, 50, 20, 90, 55};
   int phase_ctrl [PHASE_COUNT] = '{5, 5, 20, 20, 80, 20};
   int phase_hdr  [PHASE_COUNT] = '{30, 5, 30, 30, 10, 30};

   trimming_switch_queue_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic req_type push_of(logic [TAG_WIDTH-1:0] tag, logic [4:0] flags);
      req_type it;
      it.func        = FUNC_PUSH;
      it.packet_tag  = tag;
      {it.ack_flag, it.syn_flag, it.nack_flag, it.header_only, it.pull_flag} = flags;
      return it;
   endfunction

   function automatic rsp_type queued_as(logic [2:0] status);
      return '{push_status: status, default: '0};
   endfunction

   function automatic rsp_type popped(logic [TAG_WIDTH-1:0] tag, logic trimmed, logic [1:0] src);
      return '{out_valid: 1'b1, out_tag: tag, out_trimmed: trimmed, out_source: src,
               push_status: ST_CONTROL};
   endfunction

   function automatic rsp_type serve_or_enqueue(req_type it);
      rsp_type          r;
      logic [HDR_W-1:0] h;
      r = '0;
      if (it.func == FUNC_PUSH) begin
         if (it.ack_flag | it.syn_flag | it.nack_flag) begin
            if (ctl_cnt >= CONTROL_DEPTH) begin
               r.push_status = ST_DROPPED;
            end else begin
               ctl_mem[ctl_wr] = it.packet_tag;
               ctl_wr  = ctl_wr + 1'b1;
               ctl_cnt = ctl_cnt + 1;
               r.push_status = ST_CONTROL;
            end
         end else if (it.header_only | it.pull_flag) begin
            if (hdr_cnt >= HEADER_DEPTH) begin
               r.push_status = ST_DROPPED;
            end else begin
               hdr_mem[hdr_wr] = {1'b0, it.packet_tag};
               hdr_wr  = hdr_wr + 1'b1;
               hdr_cnt = hdr_cnt + 1;
               r.push_status = ST_HEADER;
            end
         end else if (data_cnt >= int'(capacity) || data_cnt >= DATA_DEPTH) begin
            if (hdr_cnt >= HEADER_DEPTH) begin
               r.push_status = ST_DROPPED;
            end else begin
               hdr_mem[hdr_wr] = {1'b1, it.packet_tag};
               hdr_wr  = hdr_wr + 1'b1;
               hdr_cnt = hdr_cnt + 1;
               r.push_status = ST_TRIMMED;
            end
         end else begin
            data_mem[data_wr] = it.packet_tag;
            data_wr  = data_wr + 1'b1;
            data_cnt = data_cnt + 1;
            r.push_status = ST_DATA;
         end
      end else if (ctl_cnt != 0) begin
         r = popped(ctl_mem[ctl_rd], 1'b0, SRC_CONTROL);
         ctl_rd  = ctl_rd + 1'b1;
         ctl_cnt = ctl_cnt - 1;
      end else if (hdr_cnt != 0 || data_cnt != 0) begin
         if (data_cnt != 0 && (hdr_cnt == 0 || share_turn == 0)) begin
            r = popped(data_mem[data_rd], 1'b0, SRC_DATA);
            data_rd  = data_rd + 1'b1;
            data_cnt = data_cnt - 1;
         end else begin
            h = hdr_mem[hdr_rd];
            r = popped(h[TAG_WIDTH-1:0], h[TAG_WIDTH], SRC_HEADER);
            hdr_rd  = hdr_rd + 1'b1;
            hdr_cnt = hdr_cnt - 1;
         end
         // share counter moves only when both fifos had something
         if (r.out_source == SRC_DATA ? hdr_cnt != 0 : data_cnt != 0)
            share_turn = (share_turn + 1 >= SHARE_PERIOD) ? 0 : share_turn + 1;
      end
      return r;
   endfunction

   function automatic req_type random_beat(int push_pct, int ctrl_pct, int hdr_pct);
      req_type it;
      int      pick;
      it.packet_tag = TAG_WIDTH'($urandom);
      {it.ack_flag, it.syn_flag, it.nack_flag, it.header_only, it.pull_flag} = 5'($urandom);
      if ($urandom_range(99) < push_pct) begin
         it.func = FUNC_PUSH;
         pick = $urandom_range(99);
         if (pick < ctrl_pct) begin
            if (!(it.ack_flag | it.syn_flag | it.nack_flag)) begin
               case ($urandom_range(2))
                  0: it.ack_flag = 1'b1;
                  1: it.syn_flag = 1'b1;
                  default: it.nack_flag = 1'b1;
               endcase
            end
         end else if (pick < ctrl_pct + hdr_pct) begin
            {it.ack_flag, it.syn_flag, it.nack_flag} = '0;
            if (!(it.header_only | it.pull_flag)) begin
               if ($urandom_range(1) == 0) it.header_only = 1'b1;
               else it.pull_flag = 1'b1;
            end
         end else begin
            {it.ack_flag, it.syn_flag, it.nack_flag, it.header_only, it.pull_flag} = '0;
         end
      end else begin
         it.func = FUNC_POP;
      end
      return it;
   endfunction

   task automatic send_beat(input req_type it, input logic typed, input rsp_type typed_want);
      rsp_type want;
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy !== 1'b0);
      want = serve_or_enqueue(it);
      if (typed) want = typed_want;
      awaited_outcomes.push_back(want);
      beats_sent++;
      if (it.func == FUNC_POP) begin
         if (want.out_valid) served_pops++;
         else empty_pops++;
      end else if (want.push_status == ST_TRIMMED) begin
         trimmed_n++;
      end else if (want.push_status == ST_DROPPED) begin
         dropped_n++;
      end
   endtask

   task automatic drain;
      while (awaited_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_WIDTH-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      capacity  = value;
      cap_writes++;
   endtask

   task automatic check_beat(input rsp_type got);
      rsp_type want;
      if (awaited_outcomes.size() == 0) begin
         $error("result beat with nothing expected: %h", got);
         errors++;
      end else begin
         want = awaited_outcomes.pop_front();
         if (got.out_valid !== want.out_valid) begin
            $error("out_valid expected %0d got %0d", want.out_valid, got.out_valid);
            errors++;
         end
         if (got.out_tag !== want.out_tag) begin
            $error("out_tag expected %h got %h", want.out_tag, got.out_tag);
            errors++;
         end
         if (got.out_trimmed !== want.out_trimmed) begin
            $error("out_trimmed expected %0d got %0d", want.out_trimmed, got.out_trimmed);
            errors++;
         end
         if (got.out_source !== want.out_source) begin
            $error("out_source expected %0d got %0d", want.out_source, got.out_source);
            errors++;
         end
         if (got.push_status !== want.push_status) begin
            $error("push_status expected %0d got %0d", want.push_status, got.push_status);
            errors++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) check_beat(rsp_item);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("trimming_switch_queue_core_tb failed");
         $finish;
      end
   end

   initial begin
      plan.push_back('{1'b0, '0, POP_BEAT, 1'b1, '0});
      plan.push_back('{1'b0, '0, push_of(16'hFFFF, 5'b00000), 1'b1, queued_as(ST_DATA)});
      plan.push_back('{1'b0, '0, push_of(16'h0000, 5'b10000), 1'b1, queued_as(ST_CONTROL)});
      plan.push_back('{1'b0, '0, push_of(16'h1234, 5'b01000), 1'b1, queued_as(ST_CONTROL)});
      plan.push_back('{1'b0, '0, push_of(16'h8001, 5'b00100), 1'b1, queued_as(ST_CONTROL)});
      plan.push_back('{1'b0, '0, push_of(16'h8000, 5'b11111), 1'b1, queued_as(ST_CONTROL)});
      plan.push_back('{1'b0, '0, push_of(16'hABCD, 5'b00010), 1'b1, queued_as(ST_HEADER)});
      plan.push_back('{1'b0, '0, push_of(16'h5432, 5'b00001), 1'b1, queued_as(ST_HEADER)});
      plan.push_back('{1'b0, '0, push_of(16'h7FFF, 5'b00011), 1'b1, queued_as(ST_HEADER)});
      plan.push_back('{1'b0, '0, push_of(16'h0001, 5'b00000), 1'b1, queued_as(ST_DATA)});
      plan.push_back('{1'b0, '0, POP_BEAT, 1'b1, popped(16'h0000, 1'b0, SRC_CONTROL)});
      plan.push_back('{1'b0, '0, POP_BEAT, 1'b1, popped(16'h1234, 1'b0, SRC_CONTROL)});
      plan.push_back('{1'b0, '0, POP_BEAT, 1'b1, popped(16'h8001, 1'b0, SRC_CONTROL)});
      plan.push_back('{1'b0, '0, POP_BEAT, 1'b1, popped(16'h8000, 1'b0, SRC_CONTROL)});
      // header and data both waiting: share counter decides
      repeat (5) plan.push_back('{1'b0, '0, POP_BEAT, 1'b0, '0});
      plan.push_back('{1'b0, '0, POP_BEAT, 1'b1, '0});
      plan.push_back('{1'b1, 7'd0, POP_BEAT, 1'b0, '0});
      plan.push_back('{1'b0, '0, push_of(16'hFFFF, 5'b00000), 1'b1, queued_as(ST_TRIMMED)});
      plan.push_back('{1'b0, '0, POP_BEAT, 1'b1, popped(16'hFFFF, 1'b1, SRC_HEADER)});
      plan.push_back('{1'b0, '0, POP_BEAT, 1'b1, '0});

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].set_cap) begin
            start <= 1'b0;
            drain();
            write_capacity(plan[i].cap);
         end else begin
            send_beat(plan[i].item, plan[i].typed, plan[i].want);
         end
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         start <= 1'b0;
         drain();
         write_capacity(CAP_WIDTH'(phase_cap[p]));
         for (int n = 0; n < PHASE_BEATS; n++) begin
            send_beat(random_beat(phase_push[p], phase_ctrl[p], phase_hdr[p]), 1'b0, '0);
            if (n == PHASE_BEATS - 1 || $urandom_range(99) < phase_idle[p]) begin
               start <= 1'b0;
               do @(posedge clock); while ($urandom_range(99) < phase_idle[p]);
            end
         end
      end

      while (awaited_outcomes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("%0d beats over %0d capacity settings, %0d pops served, %0d on an empty queue",
               beats_sent, cap_writes, served_pops, empty_pops);
      $display("%0d data beats trimmed to header, %0d pushes dropped on a full fifo",
               trimmed_n, dropped_n);
      if (errors == 0) begin
         $display("trimming_switch_queue_core_tb passed");
      end else begin
         $display("trimming_switch_queue_core_tb failed");
      end
      $finish;
   end

endmodule
